/* sv/vmp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vmp_pkg: shared types, constants and divider steps
// Word formats carried between the pipeline sections of the perturber.
// ----------------------------------------------------------------------------
package vmp_pkg;

	localparam int TDIV_STAGES = 8;   // 16 taper quotient bits, 2 per stage
	localparam int VDIV_STAGES = 9;   // 18 velocity quotient bits, 2 per stage
	localparam int DIV_STEPS   = 2;

	localparam logic [15:0] SCALE_RST  = 16'd6554;
	localparam logic [17:0] VP_LIM_RST = 18'd152000;
	localparam logic [17:0] VS_LIM_RST = 18'd96000;
	localparam logic [12:0] LAYERS_RST = 13'd1250;
	localparam logic [12:0] TAPER_RST  = 13'd937;
	localparam logic [17:0] WATER_RST  = 18'd0;
	localparam logic [17:0] VAL_MAX    = 18'h3FFFF;

	typedef enum logic [2:0] {
		CFG_SCALE    = 3'd0,
		CFG_VP_LIMIT = 3'd1,
		CFG_VS_LIMIT = 3'd2,
		CFG_LAYERS   = 3'd3,
		CFG_TAPER    = 3'd4,
		CFG_WATER    = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic               live;     // point gets perturbed
		logic               tap_en;   // layer inside the taper zone
		logic signed [31:0] sprod;    // scale * sample
		logic [17:0]        vp;
		logic [17:0]        vs;
		logic [17:0]        rho;
	} front_t;

	typedef struct packed {
		logic [12:0] rem;
		logic [12:0] den;
		logic [15:0] quo;
		front_t      side;
	} td_t;

	typedef struct packed {
		logic        live;
		logic        ovf_p;
		logic        ovf_s;
		logic        dens_zero;
		logic [17:0] vp;
		logic [17:0] vs;
		logic [17:0] rho;       // original density for pass-through points
		logic [31:0] dvs;
		logic [31:0] rem_p;
		logic [31:0] rem_s;
		logic [17:0] qp;
		logic [17:0] qs;
		logic [49:0] dens;
	} vd_t;

	function automatic td_t tdiv_step(td_t x);
		td_t y;
		logic [13:0] r2;
		y = x;
		for (int i = 0; i < DIV_STEPS; i++) begin
			r2 = {y.rem, 1'b0};
			if (r2 >= {1'b0, y.den}) begin
				y.rem = 13'(r2 - {1'b0, y.den});
				y.quo = {y.quo[14:0], 1'b1};
			end else begin
				y.rem = r2[12:0];
				y.quo = {y.quo[14:0], 1'b0};
			end
		end
		return y;
	endfunction

	function automatic vd_t vdiv_step(vd_t x);
		vd_t y;
		logic [32:0] rp;
		logic [32:0] rs;
		y = x;
		for (int i = 0; i < DIV_STEPS; i++) begin
			rp = {y.rem_p, 1'b0};
			rs = {y.rem_s, 1'b0};
			if (rp >= {1'b0, y.dvs}) begin
				y.rem_p = 32'(rp - {1'b0, y.dvs});
				y.qp    = {y.qp[16:0], 1'b1};
			end else begin
				y.rem_p = rp[31:0];
				y.qp    = {y.qp[16:0], 1'b0};
			end
			if (rs >= {1'b0, y.dvs}) begin
				y.rem_s = 32'(rs - {1'b0, y.dvs});
				y.qs    = {y.qs[16:0], 1'b1};
			end else begin
				y.rem_s = rs[31:0];
				y.qs    = {y.qs[16:0], 1'b0};
			end
		end
		return y;
	endfunction

endpackage
`default_nettype wire

/* sv/velocity_model_perturber.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// velocity_model_perturber: random heterogeneity on a layered velocity model
// Perturbs P/S velocity and density of one grid point per word.
// ----------------------------------------------------------------------------
// One word enters per clock when the output side takes every word. The
// pipeline is made up of two restoring
// dividers: the taper divider (8 stages, 2 bits each) and the pair of
// velocity dividers (9 stages, 2 bits each), plus front end, two multiply
// stages, a divisor stage and the output register. Every stage has its own
// valid bit and moves whenever the stage after it is free, so bubbles close
// up under stall and the input keeps taking words while a result waits.
// Water points (S velocity at or below the threshold) and layers at or
// beyond perturb_layers pass through with vp_clamped low. Configuration
// registers are read live; write them only while the pipeline is empty.
// ----------------------------------------------------------------------------
module velocity_model_perturber (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [17:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [11:0] layer_index,
	input  wire logic signed [15:0] hetero_sample,
	input  wire logic [17:0] p_velocity_in,
	input  wire logic [17:0] s_velocity_in,
	input  wire logic [17:0] density_in,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [17:0]      p_velocity_out,
	output logic [17:0]      s_velocity_out,
	output logic [17:0]      density_out,
	output logic             vp_clamped
);
	import vmp_pkg::*;

	// configuration registers
	logic [15:0] scale_q;
	logic [17:0] vp_limit_q;
	logic [17:0] vs_limit_q;
	logic [12:0] layers_q;
	logic [12:0] taper_q;
	logic [17:0] water_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q    <= SCALE_RST;
			vp_limit_q <= VP_LIM_RST;
			vs_limit_q <= VS_LIM_RST;
			layers_q   <= LAYERS_RST;
			taper_q    <= TAPER_RST;
			water_q    <= WATER_RST;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				CFG_SCALE:    scale_q    <= cfg_data[15:0];
				CFG_VP_LIMIT: vp_limit_q <= cfg_data;
				CFG_VS_LIMIT: vs_limit_q <= cfg_data;
				CFG_LAYERS:   layers_q   <= cfg_data[12:0];
				CFG_TAPER:    taper_q    <= cfg_data[12:0];
				CFG_WATER:    water_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage enables, back to front
	logic en1, en10, en11, en12, en22;
	logic tdiv_in_ready, tdiv_out_valid;
	logic vdiv_in_ready, vdiv_out_valid;
	td_t  tdiv_out;
	vd_t  vdiv_out;

	// ---- stage 1: classify point, taper operands, scale * sample
	logic        valid_s1;
	td_t         data_s1;
	td_t         front;
	logic signed [32:0] sprod_full;

	always_comb begin
		sprod_full        = $signed({1'b0, scale_q}) * hetero_sample;
		front.side.live   = (s_velocity_in > water_q) && ({1'b0, layer_index} < layers_q);
		front.side.tap_en = ({1'b0, layer_index} >= taper_q);
		front.side.sprod  = sprod_full[31:0];
		front.side.vp     = p_velocity_in;
		front.side.vs     = s_velocity_in;
		front.side.rho    = density_in;
		// (D - N) reduces to perturb_layers - k - 1
		front.rem         = 13'(layers_q - {1'b0, layer_index} - 13'd1);
		front.den         = 13'(layers_q - taper_q);
		front.quo         = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (en1) valid_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en1) data_s1 <= front;
	end

	vmp_taper_div u_tdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_ready  (tdiv_in_ready),
		.in_data   (data_s1),
		.out_valid (tdiv_out_valid),
		.out_ready (en10),
		.out_data  (tdiv_out)
	);

	// ---- stage 10: full product scale * sample * taper
	logic               valid_s10;
	logic signed [49:0] pf_s10;
	front_t             side_s10;
	logic [16:0]        taper;

	assign taper = tdiv_out.side.tap_en ? {1'b0, tdiv_out.quo} : 17'h10000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s10 <= 1'b0;
		else if (en10) valid_s10 <= tdiv_out_valid;
	end
	always_ff @(posedge clk) begin
		if (en10) begin
			pf_s10   <= tdiv_out.side.sprod * $signed({1'b0, taper});
			side_s10 <= tdiv_out.side;
		end
	end

	// ---- stage 11: p, divisor 1-p, overflow flags, multiplier 1+p
	logic signed [31:0] p_q30;
	logic signed [32:0] dvs_full;
	logic signed [32:0] mul_full;
	logic               valid_s11;
	logic               live_s11, ovf_p_s11, ovf_s_s11, mzero_s11;
	logic [31:0]        dvs_s11;
	logic [31:0]        mul_s11;
	logic [17:0]        vp_s11, vs_s11, rho_s11;
	logic               dvs_bad;

	always_comb begin
		p_q30    = pf_s10[47:16];          // arithmetic shift floors
		dvs_full = 33'sd1073741824 - {p_q30[31], p_q30};
		mul_full = 33'sd1073741824 + {p_q30[31], p_q30};
		dvs_bad  = dvs_full[32] || (dvs_full == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s11 <= 1'b0;
		else if (en11) valid_s11 <= valid_s10;
	end
	always_ff @(posedge clk) begin
		if (en11) begin
			live_s11  <= side_s10.live;
			// quotient of 2^18 or more always clamps
			ovf_p_s11 <= dvs_bad || ({2'b0, side_s10.vp, 12'b0} >= dvs_full[31:0]);
			ovf_s_s11 <= dvs_bad || ({2'b0, side_s10.vs, 12'b0} >= dvs_full[31:0]);
			mzero_s11 <= mul_full[32] || (mul_full == '0);
			dvs_s11   <= dvs_full[31:0];
			mul_s11   <= mul_full[31:0];
			vp_s11    <= side_s10.vp;
			vs_s11    <= side_s10.vs;
			rho_s11   <= side_s10.rho;
		end
	end

	// ---- stage 12: density product, divider seed
	logic valid_s12;
	vd_t  data_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s12 <= 1'b0;
		else if (en12) valid_s12 <= valid_s11;
	end
	always_ff @(posedge clk) begin
		if (en12) begin
			data_s12.live      <= live_s11;
			data_s12.ovf_p     <= ovf_p_s11;
			data_s12.ovf_s     <= ovf_s_s11;
			data_s12.dens_zero <= mzero_s11;
			data_s12.vp        <= vp_s11;
			data_s12.vs        <= vs_s11;
			data_s12.rho       <= rho_s11;
			data_s12.dvs       <= dvs_s11;
			data_s12.rem_p     <= {2'b0, vp_s11, 12'b0};
			data_s12.rem_s     <= {2'b0, vs_s11, 12'b0};
			data_s12.qp        <= '0;
			data_s12.qs        <= '0;
			data_s12.dens      <= 50'(rho_s11 * mul_s11);
		end
	end

	vmp_vel_div u_vdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s12),
		.in_ready  (vdiv_in_ready),
		.in_data   (data_s12),
		.out_valid (vdiv_out_valid),
		.out_ready (en22),
		.out_data  (vdiv_out)
	);

	// ---- stage 22: clamp, saturate, pass-through, output register
	logic        valid_s22;
	logic [17:0] vp_s22, vs_s22, rho_s22;
	logic        vpc_s22;
	logic [17:0] vp_n, vs_n, rho_n;
	logic        vpc_n;
	logic [19:0] dens_hi;

	always_comb begin
		dens_hi = vdiv_out.dens[49:30];
		if (!vdiv_out.live) begin
			vp_n  = vdiv_out.vp;
			vs_n  = vdiv_out.vs;
			rho_n = vdiv_out.rho;
			vpc_n = 1'b0;
		end else begin
			if (vdiv_out.ovf_p || (vdiv_out.qp > vp_limit_q)) begin
				vp_n  = vp_limit_q;
				vpc_n = 1'b1;
			end else begin
				vp_n  = vdiv_out.qp;
				vpc_n = 1'b0;
			end
			if (vdiv_out.ovf_s || (vdiv_out.qs > vs_limit_q)) vs_n = vs_limit_q;
			else vs_n = vdiv_out.qs;
			if (vdiv_out.dens_zero) rho_n = '0;
			else if (dens_hi > {2'b0, VAL_MAX}) rho_n = VAL_MAX;
			else rho_n = dens_hi[17:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s22 <= 1'b0;
		else if (en22) valid_s22 <= vdiv_out_valid;
	end
	always_ff @(posedge clk) begin
		if (en22) begin
			vp_s22  <= vp_n;
			vs_s22  <= vs_n;
			rho_s22 <= rho_n;
			vpc_s22 <= vpc_n;
		end
	end

	// ---- handshake
	assign en22 = !valid_s22 || !out_stall;
	assign en12 = !valid_s12 || vdiv_in_ready;
	assign en11 = !valid_s11 || en12;
	assign en10 = !valid_s10 || en11;
	assign en1  = !valid_s1 || tdiv_in_ready;

	assign in_stall       = !en1;
	assign out_valid      = valid_s22;
	assign p_velocity_out = vp_s22;
	assign s_velocity_out = vs_s22;
	assign density_out    = rho_s22;
	assign vp_clamped     = vpc_s22;

	// an empty output register never holds the input back
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> valid_s1)
		else $error("accepted word lost at front stage");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		vdiv_out_valid && en22 |=> out_valid)
		else $error("divider result not captured");

endmodule
`default_nettype wire

/* sv/vmp_taper_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vmp_taper_div: pipelined taper divider
// Restoring division of the taper fraction, two quotient bits per stage.
// ----------------------------------------------------------------------------
module vmp_taper_div (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire vmp_pkg::td_t  in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output vmp_pkg::td_t       out_data
);
	import vmp_pkg::*;

	logic valid_s [TDIV_STAGES];
	td_t  data_s  [TDIV_STAGES];
	logic en      [TDIV_STAGES];

	genvar g;
	generate
		for (g = 0; g < TDIV_STAGES; g++) begin : g_stage
			if (g == TDIV_STAGES - 1) begin : g_last
				assign en[g] = !valid_s[g] || out_ready;
			end else begin : g_mid
				assign en[g] = !valid_s[g] || en[g+1];
			end
			if (g == 0) begin : g_first
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) valid_s[g] <= 1'b0;
					else if (en[g]) valid_s[g] <= in_valid;
				end
				always_ff @(posedge clk) begin
					if (en[g]) data_s[g] <= tdiv_step(in_data);
				end
			end else begin : g_next
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) valid_s[g] <= 1'b0;
					else if (en[g]) valid_s[g] <= valid_s[g-1];
				end
				always_ff @(posedge clk) begin
					if (en[g]) data_s[g] <= tdiv_step(data_s[g-1]);
				end
			end
		end
	endgenerate

	assign in_ready  = en[0];
	assign out_valid = valid_s[TDIV_STAGES-1];
	assign out_data  = data_s[TDIV_STAGES-1];

	// partial remainder stays below the divisor on tapered points
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[0] && data_s[0].side.live && data_s[0].side.tap_en |->
		data_s[0].rem < data_s[0].den)
		else $error("taper remainder out of range");

endmodule
`default_nettype wire

/* sv/vmp_vel_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vmp_vel_div: pipelined velocity dividers
// P and S quotients v*2^30/(1-p) side by side, two bits per stage.
// ----------------------------------------------------------------------------
module vmp_vel_div (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire vmp_pkg::vd_t  in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output vmp_pkg::vd_t       out_data
);
	import vmp_pkg::*;

	logic valid_s [VDIV_STAGES];
	vd_t  data_s  [VDIV_STAGES];
	logic en      [VDIV_STAGES];

	genvar g;
	generate
		for (g = 0; g < VDIV_STAGES; g++) begin : g_stage
			if (g == VDIV_STAGES - 1) begin : g_last
				assign en[g] = !valid_s[g] || out_ready;
			end else begin : g_mid
				assign en[g] = !valid_s[g] || en[g+1];
			end
			if (g == 0) begin : g_first
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) valid_s[g] <= 1'b0;
					else if (en[g]) valid_s[g] <= in_valid;
				end
				always_ff @(posedge clk) begin
					if (en[g]) data_s[g] <= vdiv_step(in_data);
				end
			end else begin : g_next
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) valid_s[g] <= 1'b0;
					else if (en[g]) valid_s[g] <= valid_s[g-1];
				end
				always_ff @(posedge clk) begin
					if (en[g]) data_s[g] <= vdiv_step(data_s[g-1]);
				end
			end
		end
	endgenerate

	assign in_ready  = en[0];
	assign out_valid = valid_s[VDIV_STAGES-1];
	assign out_data  = data_s[VDIV_STAGES-1];

	// no-overflow points keep remainder below divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[0] && data_s[0].live && !data_s[0].ovf_p |->
		data_s[0].rem_p < data_s[0].dvs)
		else $error("P velocity remainder out of range");

endmodule
`default_nettype wire

/* tb/velocity_model_perturber_test.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// velocity_model_perturber_test: self-checking bench for the perturber
// Drives grid-point words through a stalling handshake, predicts each
// perturbed triple in fixed point, and compares the results in arrival order.
// Several register settings are visited, with writes only while idle.
// ----------------------------------------------------------------------------
module velocity_model_perturber_test;
	timeunit 1ns;
	timeprecision 1ps;
	import vmp_pkg::*;

	typedef struct packed {
		logic [11:0]        k;
		logic signed [15:0] smp;
		logic [17:0]        vp;
		logic [17:0]        vs;
		logic [17:0]        rho;
	} point_t;

	typedef struct packed {
		logic [17:0] vp;
		logic [17:0] vs;
		logic [17:0] rho;
		logic        clamp;
	} triple_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [17:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [11:0] layer_index = '0;
	logic signed [15:0] hetero_sample = '0;
	logic [17:0] p_velocity_in = '0;
	logic [17:0] s_velocity_in = '0;
	logic [17:0] density_in = '0;
	logic out_valid;
	logic out_stall = 1'b1;
	logic [17:0] p_velocity_out;
	logic [17:0] s_velocity_out;
	logic [17:0] density_out;
	logic vp_clamped;

	velocity_model_perturber dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor's copy of the registers
	logic [15:0] scale_r  = SCALE_RST;
	logic [17:0] vplim_r  = VP_LIM_RST;
	logic [17:0] vslim_r  = VS_LIM_RST;
	logic [12:0] layers_r = LAYERS_RST;
	logic [12:0] tstart_r = TAPER_RST;
	logic [17:0] water_r  = WATER_RST;

	point_t  pending_points[$];
	triple_t expected_triples[$];
	int      errors = 0;
	int      send_idle_pct = 26;   // sender gap chance, percent
	int      recv_idle_pct = 67;   // receiver stall chance, percent
	int      hold_cycles = 0;      // long receiver hold-off when nonzero

	// velocity divided by (1 - p), saturating at the limit
	function automatic logic [18:0] divide_velocity(logic [17:0] v,
			longint divisor, logic [17:0] lim);
		longint q;
		if (divisor <= 0) return {1'b1, lim};
		q = (longint'(v) << 30) / divisor;
		if (q > longint'(lim)) return {1'b1, lim};
		return {1'b0, q[17:0]};
	endfunction

	function automatic triple_t perturb_point(point_t pt);
		triple_t r;
		longint taper, num, den, prod, p, dens;
		logic [18:0] qp, qs;
		r = '{vp: pt.vp, vs: pt.vs, rho: pt.rho, clamp: 1'b0};
		if (pt.vs > water_r && 13'(pt.k) < layers_r) begin
			taper = 65536;
			if (13'(pt.k) >= tstart_r) begin
				num = longint'(pt.k) + 1 - longint'(tstart_r);
				den = longint'(layers_r) - longint'(tstart_r);
				taper = ((den - num) << 16) / den;
			end
			prod = longint'(scale_r) * longint'(pt.smp) * taper;
			// floor division by 2^16
			p = (prod >= 0) ? (prod >>> 16) : -((-prod + 65535) >>> 16);
			qp = divide_velocity(pt.vp, (64'sd1 << 30) - p, vplim_r);
			qs = divide_velocity(pt.vs, (64'sd1 << 30) - p, vslim_r);
			r.vp = qp[17:0];
			r.clamp = qp[18];
			r.vs = qs[17:0];
			dens = longint'(pt.rho) * ((64'sd1 << 30) + p);
			if (dens <= 0) r.rho = '0;
			else if ((dens >>> 30) > longint'(VAL_MAX)) r.rho = VAL_MAX;
			else r.rho = 18'(dens >>> 30);
		end
		return r;
	endfunction

	// driver: one word per accepted handshake, random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (!in_valid || !in_stall) begin
				if (pending_points.size() > 0 &&
						$urandom_range(99) >= send_idle_pct) begin
					point_t pt;
					pt = pending_points.pop_front();
					expected_triples.push_back(perturb_point(pt));
					in_valid      <= 1'b1;
					layer_index   <= pt.k;
					hetero_sample <= pt.smp;
					p_velocity_in <= pt.vp;
					s_velocity_in <= pt.vs;
					density_in    <= pt.rho;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall: random, or a long hold-off while the sender keeps going
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// monitor: compare each accepted word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_triples.size() == 0) begin
				$display("%0t unexpected word vp=%0d vs=%0d rho=%0d clamp=%0b", $time,
					p_velocity_out, s_velocity_out, density_out, vp_clamped);
				errors++;
			end else begin
				triple_t e;
				e = expected_triples.pop_front();
				if (e.vp !== p_velocity_out || e.vs !== s_velocity_out ||
						e.rho !== density_out || e.clamp !== vp_clamped) begin
					$display("%0t mismatch exp vp=%0d vs=%0d rho=%0d clamp=%0b",
						$time, e.vp, e.vs, e.rho, e.clamp);
					$display("%0t          got vp=%0d vs=%0d rho=%0d clamp=%0b",
						$time, p_velocity_out, s_velocity_out, density_out, vp_clamped);
					errors++;
				end
			end
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [17:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_SCALE:    scale_r  = val[15:0];
			CFG_VP_LIMIT: vplim_r  = val;
			CFG_VS_LIMIT: vslim_r  = val;
			CFG_LAYERS:   layers_r = val[12:0];
			CFG_TAPER:    tstart_r = val[12:0];
			default:      water_r  = val;
		endcase
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic set_config(logic [15:0] sc, logic [17:0] vpl, logic [17:0] vsl,
			logic [12:0] nl, logic [12:0] ts, logic [17:0] wt);
		write_reg(CFG_SCALE, 18'(sc));
		write_reg(CFG_VP_LIMIT, vpl);
		write_reg(CFG_VS_LIMIT, vsl);
		write_reg(CFG_LAYERS, 18'(nl));
		write_reg(CFG_TAPER, 18'(ts));
		write_reg(CFG_WATER, wt);
	endtask

	// wait until every queued word has gone through and come back
	task automatic drain;
		while (pending_points.size() > 0 || expected_triples.size() > 0 || in_valid)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	function automatic point_t random_point(logic [12:0] nl);
		point_t pt;
		int lim;
		lim = (nl == 0) ? 4095 : ((nl > 4096) ? 4095 : int'(nl) - 1);
		// mostly perturbed layers, some beyond
		pt.k   = ($urandom_range(9) < 8) ? 12'($urandom_range(lim)) : 12'($urandom);
		pt.smp = 16'($urandom);
		case ($urandom_range(4))
			0: pt.smp = 16'($urandom_range(2000)) - 16'sd1000;
			1: pt.smp = ($urandom_range(1)) ? 16'sh7FFF : 16'sh8000;
			default: ;
		endcase
		pt.vp  = ($urandom_range(7) == 0) ? 18'($urandom) : 18'($urandom_range(160000));
		pt.vs  = ($urandom_range(9) == 0) ? 18'($urandom_range(200)) : 18'($urandom);
		pt.rho = 18'($urandom);
		return pt;
	endfunction

	task automatic random_phase(int n);
		repeat (n) pending_points.push_back(random_point(layers_r));
		drain();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: field extremes, water, unperturbed layer, taper zone
		pending_points.push_back('{12'd0, 16'sh7FFF, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF});
		pending_points.push_back('{12'd0, 16'sh8000, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF});
		pending_points.push_back('{12'd0, 16'sd0, 18'd0, 18'd1, 18'd0});
		pending_points.push_back('{12'd5, 16'sd1000, 18'd90000, 18'd0, 18'd40000});
		pending_points.push_back('{12'd1249, 16'sh7FFF, 18'd90000, 18'd50000, 18'd40000});
		pending_points.push_back('{12'd1250, 16'sh7FFF, 18'd90000, 18'd50000, 18'd40000});
		pending_points.push_back('{12'd4095, 16'sh8000, 18'd1, 18'd2, 18'd3});
		pending_points.push_back('{12'd937, 16'sh4000, 18'd150000, 18'd90000, 18'd2000});
		pending_points.push_back('{12'd936, 16'shC000, 18'd150000, 18'd95000, 18'd2000});
		drain();

		// huge scale: divisor goes non-positive, density to zero
		set_config(16'hFFFF, 18'd152000, 18'd96000, 13'd4096, 13'd4097, 18'd0);
		pending_points.push_back('{12'd10, 16'sh7FFF, 18'd1000, 18'd1000, 18'd1000});
		pending_points.push_back('{12'd10, 16'sh8000, 18'd1000, 18'd1000, 18'd1000});
		pending_points.push_back('{12'd4095, 16'sh4000, 18'd1000, 18'd1000, 18'h3FFFF});
		pending_points.push_back('{12'd0, 16'sh7FFF, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF});
		drain();

		// zero scale, zero limits, one layer, max water threshold
		set_config(16'd0, 18'd0, 18'd0, 13'd1, 13'd0, 18'h3FFFF);
		pending_points.push_back('{12'd0, 16'sh7FFF, 18'd5, 18'h3FFFF, 18'd5});
		pending_points.push_back('{12'd0, 16'sh7FFF, 18'd5, 18'h3FFFE, 18'd5});
		drain();

		// pressure: long receiver hold-off, sender keeps offering
		set_config(16'd6554, 18'd152000, 18'd96000, 13'd1250, 13'd937, 18'd100);
		hold_cycles = 200;
		random_phase(100);

		set_config(16'd20000, 18'h3FFFF, 18'h3FFFF, 13'd300, 13'd100, 18'd0);
		random_phase(300);

		send_idle_pct = 67;
		recv_idle_pct = 26;
		set_config(16'd65535, 18'd120000, 18'd70000, 13'd4096, 13'd0, 18'd500);
		random_phase(300);

		set_config(16'd3000, 18'd152000, 18'd96000, 13'd0, 13'd5, 18'd0);
		random_phase(100);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_config(16'd40000, 18'd200000, 18'd150000, 13'd2000, 13'd1999, 18'd10);
		random_phase(250);
		set_config(16'd9000, 18'd152000, 18'd96000, 13'd50, 13'd4097, 18'd0);
		random_phase(250);

		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
`default_nettype wire

/* files.f */
sv/vmp_pkg.sv
sv/vmp_taper_div.sv
sv/vmp_vel_div.sv
sv/velocity_model_perturber.sv
tb/velocity_model_perturber_test.sv
